>>> design/ffa_pkg.sv
`default_nettype none
package ffa_pkg;
	localparam int ADDR_W = 12;
	localparam int SIZE_W = 13;
	localparam int BYTES_W = 16;
	localparam int OP_W = 2;
	localparam int STAT_W = 2;
	localparam int STEP_W = 14;
	localparam int HDR_SHIFT = 4;

	localparam logic [SIZE_W-1:0] HEAP_UNITS = 13'd4096;
	localparam logic [BYTES_W-1:0] MIN_DONATE = 16'd32;
	localparam logic [ADDR_W-1:0] GROW_RESET = 12'd1024;
	localparam logic [STEP_W-1:0] ALLOC_STEP_MAX = 14'd8194;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_DONATE = 2'd2;
	localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_SMALL = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic ws_en;
		logic [ADDR_W-1:0] ws_addr;
		logic [SIZE_W-1:0] ws_data;
		logic wn_en;
		logic [ADDR_W-1:0] wn_addr;
		logic [ADDR_W-1:0] wn_data;
	} mem_req_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] next;
	} mem_rsp_t;
endpackage
`default_nettype wire

>>> design/ffa_if.sv
`default_nettype none
interface ffa_req_if import ffa_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [BYTES_W-1:0] byte_count;
	logic [ADDR_W-1:0] block_addr;
	modport source (output valid, opcode, byte_count, block_addr, input ready);
	modport sink (input valid, opcode, byte_count, block_addr, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
	logic valid;
	logic ready;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] result_addr;
	modport source (output valid, status, result_addr, input ready);
	modport sink (input valid, status, result_addr, output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/ffa_cell_mem.sv
`default_nettype none
module ffa_cell_mem import ffa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire mem_req_t req,
	output mem_rsp_t rsp
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [SIZE_W-1:0] size_mem [DEPTH];
	logic [ADDR_W-1:0] next_mem [DEPTH];
	logic [SIZE_W-1:0] size_rd;
	logic [ADDR_W-1:0] next_rd;
	logic s0_wr_q, n0_wr_q, s0_zero_q, n0_zero_q;

	always_ff @(posedge clk) begin
		if (req.ws_en) begin
			size_mem[req.ws_addr] <= req.ws_data;
		end
		if (req.wn_en) begin
			next_mem[req.wn_addr] <= req.wn_data;
		end
		if (req.rd_en) begin
			size_rd <= size_mem[req.rd_addr];
			next_rd <= next_mem[req.rd_addr];
		end
	end

	// cell 0 reads as the empty sentinel until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_wr_q <= 1'b0;
			n0_wr_q <= 1'b0;
			s0_zero_q <= 1'b0;
			n0_zero_q <= 1'b0;
		end else begin
			if (req.ws_en && req.ws_addr == '0) begin
				s0_wr_q <= 1'b1;
			end
			if (req.wn_en && req.wn_addr == '0) begin
				n0_wr_q <= 1'b1;
			end
			if (req.rd_en) begin
				s0_zero_q <= (req.rd_addr == '0) && !s0_wr_q;
				n0_zero_q <= (req.rd_addr == '0) && !n0_wr_q;
			end
		end
	end

	assign rsp.size = s0_zero_q ? '0 : size_rd;
	assign rsp.next = n0_zero_q ? '0 : next_rd;
endmodule
`default_nettype wire

>>> design/first_fit_free_list_allocator_top.sv
// First-fit free-list heap allocator over 4096 header-sized units.
// Channels: req (opcode, byte_count, block_addr) in, rsp (status,
// result_addr) out, each valid/ready; cfg writes grow_min, always ready.
// One request is worked at a time; req.ready is high only while idle.
// The free list lives in two registered-read memories (size, next) and
// every list step is one memory read, so the time taken depends on list
// length: allocate scans blocks and, when the heap grows, also walks to
// insert the grown block; free/donate walk to the insert point.
// The result sits in an output register; the next request is taken while
// it waits, and a finished request holds until the register frees.
// Reset: the list is the sentinel cell 0 alone, rover 0, break pointer 1,
// grow_min 1024. No clearing pass: cell 0 is tracked by written flags.
`default_nettype none
module first_fit_free_list_allocator_top import ffa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ffa_req_if.sink req,
	ffa_rsp_if.source rsp,
	ffa_cfg_if.sink cfg
);
	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_NXT, S_A_CHK, S_A_TAIL, S_A_RET, S_G_WR, S_D_WR,
		S_I_RD, S_I_WALK, S_I_CHKB, S_I_MRG, S_I_WRB, S_I_WRP, S_EMIT
	} state_t;

	state_t state_q;
	mem_req_t mreq;
	mem_rsp_t mrsp;

	logic [ADDR_W-1:0] grow_q, rover_q, prev_q, p_q, tail_q, bp_q, ip_q, inx_q, nbnx_q;
	logic [ADDR_W-1:0] res_addr_q, out_addr_q, dbg_unused;
	logic [SIZE_W-1:0] brk_q, units_q, nu_q, dsz_q, ipsize_q, bsz_q, nbsz_q;
	logic [STEP_W-1:0] asteps_q;
	logic [SIZE_W-1:0] isteps_q;
	logic [STAT_W-1:0] res_stat_q, out_stat_q;
	logic out_valid_q, ret_alloc_q;

	logic fit, fit_eq, found, grow_ok, pmerge;
	logic [SIZE_W-1:0] nu, new_sz, lim, dsz, units_in;
	logic [STEP_W-1:0] asteps_nx;
	logic [SIZE_W-1:0] isteps_nx;
	logic [BYTES_W:0] bytes_rnd;
	logic [ADDR_W-1:0] fb;

	assign dbg_unused = '0;

	ffa_cell_mem u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.rsp(mrsp)
	);

	always_comb begin
		bytes_rnd = {1'b0, req.byte_count} + (BYTES_W+1)'(15);
		units_in = bytes_rnd[BYTES_W:HDR_SHIFT] + SIZE_W'(1);
		lim = HEAP_UNITS - {1'b0, req.block_addr};
		dsz = {1'b0, req.byte_count[BYTES_W-1:HDR_SHIFT]} - SIZE_W'(1);
		if (dsz > lim) begin
			dsz = lim;
		end
		fb = req.block_addr - ADDR_W'(1);
		fit = mrsp.size >= units_q;
		fit_eq = mrsp.size == units_q;
		new_sz = mrsp.size - units_q;
		nu = (units_q < {1'b0, grow_q}) ? {1'b0, grow_q} : units_q;
		grow_ok = (brk_q <= HEAP_UNITS) && (nu <= HEAP_UNITS - brk_q);
		asteps_nx = asteps_q + STEP_W'(1);
		isteps_nx = isteps_q + SIZE_W'(1);
		found = (bp_q > ip_q && bp_q < mrsp.next)
			|| (ip_q >= mrsp.next && (bp_q > ip_q || bp_q < mrsp.next));
		pmerge = ({2'b0, ip_q} + {1'b0, ipsize_q}) == {2'b0, bp_q};
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			S_A_RD, S_I_RD: begin
				mreq.rd_en = 1'b1;
				mreq.rd_addr = rover_q;
			end
			S_A_NXT: begin
				mreq.rd_en = 1'b1;
				mreq.rd_addr = mrsp.next;
			end
			S_A_CHK: begin
				if (fit && fit_eq) begin
					mreq.wn_en = 1'b1;
					mreq.wn_addr = prev_q;
					mreq.wn_data = mrsp.next;
				end else if (fit) begin
					mreq.ws_en = 1'b1;
					mreq.ws_addr = p_q;
					mreq.ws_data = new_sz;
				end else if (p_q != rover_q) begin
					mreq.rd_en = 1'b1;
					mreq.rd_addr = mrsp.next;
				end
			end
			S_A_TAIL: begin
				mreq.ws_en = 1'b1;
				mreq.ws_addr = tail_q;
				mreq.ws_data = units_q;
			end
			S_G_WR: begin
				mreq.ws_en = 1'b1;
				mreq.ws_addr = brk_q[ADDR_W-1:0];
				mreq.ws_data = nu_q;
			end
			S_D_WR: begin
				mreq.ws_en = 1'b1;
				mreq.ws_addr = bp_q;
				mreq.ws_data = dsz_q;
			end
			S_I_WALK: begin
				mreq.rd_en = 1'b1;
				mreq.rd_addr = found ? bp_q : mrsp.next;
			end
			S_I_CHKB: begin
				mreq.rd_en = 1'b1;
				mreq.rd_addr = inx_q;
			end
			S_I_WRB: begin
				mreq.ws_en = 1'b1;
				mreq.ws_addr = bp_q;
				mreq.ws_data = nbsz_q;
				mreq.wn_en = 1'b1;
				mreq.wn_addr = bp_q;
				mreq.wn_data = nbnx_q;
			end
			S_I_WRP: begin
				mreq.ws_en = pmerge;
				mreq.ws_addr = ip_q;
				mreq.ws_data = ipsize_q + nbsz_q;
				mreq.wn_en = 1'b1;
				mreq.wn_addr = ip_q;
				mreq.wn_data = pmerge ? nbnx_q : bp_q;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grow_q <= GROW_RESET;
		end else if (cfg.valid) begin
			grow_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_stat_q;
	assign rsp.result_addr = out_addr_q | dbg_unused;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rover_q <= '0;
			brk_q <= SIZE_W'(1);
			out_valid_q <= 1'b0;
			ret_alloc_q <= 1'b0;
			asteps_q <= '0;
			isteps_q <= '0;
		end else begin
			if (rsp.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_stat_q <= ST_OK;
						res_addr_q <= '0;
						ret_alloc_q <= 1'b0;
						bp_q <= req.block_addr;
						case (req.opcode)
							OP_ALLOC: begin
								units_q <= units_in;
								asteps_q <= '0;
								state_q <= S_A_RD;
							end
							OP_FREE: begin
								bp_q <= fb;
								state_q <= (fb != '0) ? S_I_RD : S_EMIT;
							end
							OP_DONATE: begin
								dsz_q <= dsz;
								if (req.byte_count < MIN_DONATE || req.block_addr == '0) begin
									res_stat_q <= ST_SMALL;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_D_WR;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_A_RD: begin
					prev_q <= rover_q;
					state_q <= S_A_NXT;
				end
				S_A_NXT: begin
					p_q <= mrsp.next;
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (fit && fit_eq) begin
						rover_q <= prev_q;
						res_addr_q <= p_q + ADDR_W'(1);
						state_q <= S_EMIT;
					end else if (fit) begin
						tail_q <= p_q + new_sz[ADDR_W-1:0];
						state_q <= S_A_TAIL;
					end else if (p_q == rover_q) begin
						nu_q <= nu;
						if (grow_ok) begin
							state_q <= S_G_WR;
						end else begin
							res_stat_q <= ST_OOM;
							state_q <= S_EMIT;
						end
					end else begin
						prev_q <= p_q;
						p_q <= mrsp.next;
						asteps_q <= asteps_nx;
						if (asteps_nx > ALLOC_STEP_MAX) begin
							res_stat_q <= ST_OOM;
							state_q <= S_EMIT;
						end
					end
				end
				S_A_TAIL: begin
					rover_q <= prev_q;
					res_addr_q <= tail_q + ADDR_W'(1);
					state_q <= S_EMIT;
				end
				S_G_WR: begin
					bp_q <= brk_q[ADDR_W-1:0];
					brk_q <= brk_q + nu_q;
					ret_alloc_q <= 1'b1;
					state_q <= S_I_RD;
				end
				S_A_RET: begin
					asteps_q <= asteps_nx;
					if (asteps_nx > ALLOC_STEP_MAX) begin
						res_stat_q <= ST_OOM;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_D_WR: begin
					state_q <= S_I_RD;
				end
				S_I_RD: begin
					ip_q <= rover_q;
					isteps_q <= '0;
					state_q <= S_I_WALK;
				end
				S_I_WALK: begin
					if (found) begin
						inx_q <= mrsp.next;
						ipsize_q <= mrsp.size;
						state_q <= S_I_CHKB;
					end else begin
						ip_q <= mrsp.next;
						isteps_q <= isteps_nx;
						if (isteps_nx > HEAP_UNITS) begin
							state_q <= ret_alloc_q ? S_A_RET : S_EMIT;
						end
					end
				end
				S_I_CHKB: begin
					bsz_q <= mrsp.size;
					if (({2'b0, bp_q} + {1'b0, mrsp.size}) == {2'b0, inx_q}) begin
						state_q <= S_I_MRG;
					end else begin
						nbsz_q <= mrsp.size;
						nbnx_q <= inx_q;
						state_q <= S_I_WRB;
					end
				end
				S_I_MRG: begin
					nbsz_q <= bsz_q + mrsp.size;
					nbnx_q <= mrsp.next;
					state_q <= S_I_WRB;
				end
				S_I_WRB: begin
					state_q <= S_I_WRP;
				end
				S_I_WRP: begin
					rover_q <= ip_q;
					state_q <= ret_alloc_q ? S_A_RET : S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_stat_q <= res_stat_q;
						out_addr_q <= res_addr_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= HEAP_UNITS)
		else $error("break pointer past arena");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.result_addr == '0)
		else $error("address returned with failing status");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.rd_en |-> !(mreq.ws_en || mreq.wn_en))
		else $error("memory read and write in one cycle");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("request taken but sequencer idle");
endmodule
`default_nettype wire
